/* rtl/tpd_pkg.sv */
`default_nettype none

package tpd_pkg;

  // Texture format codes held in the format register.
  localparam logic [2:0] FMT_A3I5    = 3'd1;
  localparam logic [2:0] FMT_PLTT4   = 3'd2;
  localparam logic [2:0] FMT_PLTT16  = 3'd3;
  localparam logic [2:0] FMT_PLTT256 = 3'd4;
  localparam logic [2:0] FMT_A5I3    = 3'd6;
  localparam logic [2:0] FMT_DIRECT  = 3'd7;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_FORMAT      = 2'd0;
  localparam logic [1:0] REG_ZERO_TRANSP = 2'd1;
  localparam logic [1:0] REG_PAL_COUNT   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // BGR555 word that expands to (255, 0, 255).
  localparam logic [14:0] COLOR_MAGENTA = 15'h7C1F;

  typedef enum logic {
    ENT_PAL_WR = 1'b0,
    ENT_TEXEL  = 1'b1
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t   kind;
    logic [1:0]  last_k;     // index of the last pixel this item produces
    logic [7:0]  pal_index;
    logic [14:0] pal_color;
    logic [15:0] data;
    logic        eoi;
  } q_entry_t;

  typedef struct packed {
    logic [2:0] fmt;
    logic       zero_transp;
    logic [8:0] pal_count;
  } cfg_t;

  typedef struct packed {
    logic        use_ram;    // color comes from the palette read data
    logic [14:0] color;
    logic [7:0]  alpha;
    logic        run_last;
    logic        image_last;
    logic        bad;
  } pix_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // a * 255 / 7 = 36a + floor(3a / 7); the quotient uses 37/256 as reciprocal.
  function automatic logic [7:0] alpha3(input logic [2:0] a);
    logic [4:0]  y;
    logic [10:0] p;
    logic [7:0]  base;
    y    = {1'b0, a, 1'b0} + {2'b0, a};
    p    = 11'(y) * 11'd37;
    base = {a, 5'b0} + {3'b0, a, 2'b0};
    return base + {5'b0, p[10:8]};
  endfunction

  // a * 255 / 31 = 8a + floor(7a / 31); the quotient uses 265/8192 as reciprocal.
  function automatic logic [7:0] alpha5(input logic [4:0] a);
    logic [7:0]  x;
    logic [16:0] p;
    x = {a, 3'b0} - {3'b0, a};
    p = 17'(x) * 17'd265;
    return {a, 3'b0} + {5'b0, p[15:13]};
  endfunction

endpackage

`default_nettype wire

/* rtl/tpd_ram.sv */
`default_nettype none

module tpd_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tpd_front.sv */
`default_nettype none

module tpd_front
  import tpd_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire cfg_t        cfg,
  input  wire logic        q_full,
  output logic             q_push,
  output q_entry_t         q_din
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // The pixel count of a texel item is fixed by the format at accept time.
  always_comb begin
    q_din.kind      = (in_tuser == 1'b1) ? ENT_TEXEL : ENT_PAL_WR;
    q_din.pal_index = in_tdata[7:0];
    q_din.pal_color = in_tdata[22:8];
    q_din.data      = in_tdata[38:23];
    q_din.eoi       = in_tlast;
    q_din.last_k    = 2'd0;
    if (in_tuser) begin
      case (cfg.fmt)
        FMT_PLTT4:  q_din.last_k = 2'd3;
        FMT_PLTT16: q_din.last_k = 2'd1;
        default:    q_din.last_k = 2'd0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/tpd_queue.sv */
`default_nettype none

module tpd_queue
  import tpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t din,
  output logic          full,
  output logic          valid,
  output q_entry_t      head,
  input  wire logic     pop
);

  q_entry_t            entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/tpd_back.sv */
`default_nettype none

module tpd_back
  import tpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire q_entry_t    q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [1:0]  cnt_r, cnt_nxt;
  logic        s2_valid_r, s2_valid_nxt;
  pix_t        s2_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic [1:0]  out_user_r;

  logic        s2_adv, s2_free, issue, is_texel, rd_en, wr_en;
  logic [7:0]  b, idx, sh, alpha_fmt;
  logic        indexed, bad, in_range;
  pix_t        pix;
  logic [14:0] ram_rdata, color;

  assign is_texel = (q_head.kind == ENT_TEXEL);
  assign s2_adv   = s2_valid_r && (!out_valid_r || out_tready);
  assign s2_free  = !s2_valid_r || s2_adv;
  // Palette writes need no pixel slot and are popped as soon as they issue.
  assign issue    = q_valid && (!is_texel || s2_free);
  assign q_pop    = issue && (!is_texel || (cnt_r == q_head.last_k));

  assign b  = q_head.data[7:0];
  assign sh = b >> {cnt_r, 1'b0};

  always_comb begin
    idx       = b;
    alpha_fmt = 8'hFF;
    indexed   = 1'b1;
    bad       = 1'b0;
    case (cfg.fmt)
      FMT_A3I5: begin
        idx       = {3'b0, b[4:0]};
        alpha_fmt = alpha3(b[7:5]);
      end
      FMT_PLTT4: begin
        idx = {6'b0, sh[1:0]};
      end
      FMT_PLTT16: begin
        idx = cnt_r[0] ? {4'b0, b[7:4]} : {4'b0, b[3:0]};
      end
      FMT_PLTT256: begin
        idx = b;
      end
      FMT_A5I3: begin
        idx       = {5'b0, b[2:0]};
        alpha_fmt = alpha5(b[7:3]);
      end
      FMT_DIRECT: begin
        indexed   = 1'b0;
        alpha_fmt = q_head.data[15] ? 8'hFF : 8'h00;
      end
      default: begin
        indexed   = 1'b0;
        bad       = 1'b1;
        alpha_fmt = 8'h00;
      end
    endcase
  end

  assign in_range = ({1'b0, idx} < cfg.pal_count) &&
                    ({1'b0, idx} < 9'(PALETTE_DEPTH));

  always_comb begin
    pix.use_ram    = indexed && in_range;
    pix.color      = indexed ? COLOR_MAGENTA : (bad ? 15'd0 : q_head.data[14:0]);
    pix.alpha      = (indexed && cfg.zero_transp && (idx == 8'd0)) ? 8'h00 : alpha_fmt;
    pix.run_last   = (cnt_r == q_head.last_k);
    pix.image_last = (cnt_r == q_head.last_k) && q_head.eoi;
    pix.bad        = bad;
  end

  assign rd_en = issue && is_texel && pix.use_ram;
  assign wr_en = issue && !is_texel && ({1'b0, q_head.pal_index} < 9'(PALETTE_DEPTH));

  // The read data register only moves on a read, so it holds while a pixel waits.
  tpd_ram #(
    .WIDTH(15),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (wr_en),
    .waddr(q_head.pal_index[AW-1:0]),
    .wdata(q_head.pal_color),
    .re   (rd_en),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop) begin
      cnt_nxt = 2'd0;
    end else if (issue) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    s2_valid_nxt = s2_valid_r;
    if (issue && is_texel) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign color = s2_r.use_ram ? ram_rdata : s2_r.color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && is_texel) begin
      s2_r <= pix;
    end
    if (s2_adv) begin
      out_data_r <= {s2_r.alpha, expand5(color[14:10]), expand5(color[9:5]),
                     expand5(color[4:0])};
      out_last_r <= s2_r.run_last;
      out_user_r <= {s2_r.bad, s2_r.image_last};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (cnt_r <= q_head.last_k))
    else $error("pixel counter ran past the last pixel of the head item");

  a_read_fills: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s2_valid_r)
    else $error("palette read issued without a pixel in the read stage");

  a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_r.use_ram && !s2_adv) |=> (s2_valid_r && $stable(ram_rdata)))
    else $error("waiting pixel lost its palette read data");

endmodule

`default_nettype wire

/* rtl/texel_palette_to_rgba_decoder_top.sv */
`default_nettype none

// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid/in_tready     palette write or texel item
// out_     master     out_tvalid/out_tready   one RGBA8 pixel
// cfg_     APB slave  psel/penable/pready     format, zero transparency, palette count
//
// A palette write needs no pixel slot; a texel item yields four pixels for 2-bit, two for
// 4-bit and one otherwise, issued one at a time through the single read port of the palette
// RAM. From accept, a pixel passes the queue, the read stage and the output register.
// Reset clears the registers to format 4, no transparency, count 0; the palette is
// undefined until written. A four-entry queue separates input from pixel generation,
// so in_tready drops only when the queue is full.

module texel_palette_to_rgba_decoder_top
  import tpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // pal_index, pal_color, texel_data, one pad bit
  input  wire logic        in_tuser,    // req_type
  input  wire logic        in_tlast,    // end_of_image
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // red, green, blue, alpha
  output logic [1:0]       out_tuser,   // image_last, bad_format
  output logic             out_tlast,   // run_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [2:0] fmt_r;
  logic       zero_transp_r;
  logic [8:0] pal_count_r;
  logic       cfg_wr;
  cfg_t       cfg;

  logic     q_push, q_full, q_valid, q_pop;
  q_entry_t q_din, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r         <= FMT_PLTT256;
      zero_transp_r <= 1'b0;
      pal_count_r   <= 9'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FORMAT:      fmt_r         <= cfg_pwdata[2:0];
        REG_ZERO_TRANSP: zero_transp_r <= cfg_pwdata[0];
        REG_PAL_COUNT:   pal_count_r   <= cfg_pwdata[8:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FORMAT:      cfg_prdata = {29'd0, fmt_r};
      REG_ZERO_TRANSP: cfg_prdata = {31'd0, zero_transp_r};
      REG_PAL_COUNT:   cfg_prdata = {23'd0, pal_count_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.fmt         = fmt_r;
  assign cfg.zero_transp = zero_transp_r;
  assign cfg.pal_count   = pal_count_r;

  tpd_front u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  tpd_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .valid(q_valid),
    .head (q_head),
    .pop  (q_pop)
  );

  tpd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire
